@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, a, b)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

@@ rtl/tfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfe_pkg
// Constants, filter edge table and helpers for the filterbank energy block.
// ----------------------------------------------------------------------------
package tfe_pkg;
	localparam int NUM_SPECTRUM_BINS = 256;
	localparam int NUM_FILTERS       = 12;
	localparam int FILT_W            = 4;
	localparam int CNT_W             = $clog2(NUM_SPECTRUM_BINS + 1);
	localparam int BW_W              = 26;
	localparam int HZ_W              = 16;
	localparam int POWER_W           = 32;
	localparam int ACC_W             = 48;
	localparam int FREQ_W            = BW_W + CNT_W;
	localparam int CMP_W             = 40;
	localparam int DIV_W             = 32;
	localparam int Q_W               = 17;
	localparam int W_W               = 16;
	localparam int PROD_W            = POWER_W + W_W;
	localparam int CFG_IDX_W         = 2;
	localparam int CFG_DATA_W        = 26;

	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_ENABLE = 2'd3;

	localparam logic [BW_W-1:0]  BIN_WIDTH_RST  = 26'd2048000;
	localparam logic [HZ_W-1:0]  LOW_LIMIT_RST  = 16'd0;
	localparam logic [HZ_W-1:0]  HIGH_LIMIT_RST = 16'd8000;
	localparam logic [ACC_W-1:0] ACC_MAX        = {ACC_W{1'b1}};
	localparam logic [ACC_W-1:0] FLOOR_VALUE    = 48'd256;
	localparam logic [FILT_W-1:0] LAST_FILTER   = 4'(NUM_FILTERS - 1);

	localparam logic [HZ_W-1:0] EDGE_LO [NUM_FILTERS] = '{
		16'd0, 16'd0, 16'd200, 16'd400, 16'd600, 16'd800,
		16'd1000, 16'd1200, 16'd1500, 16'd2250, 16'd3000, 16'd6000};
	localparam logic [HZ_W-1:0] EDGE_HI [NUM_FILTERS] = '{
		16'd12000, 16'd200, 16'd400, 16'd600, 16'd800, 16'd1000,
		16'd1200, 16'd1500, 16'd2250, 16'd3000, 16'd6000, 16'd12000};

	function automatic logic included(input logic [FILT_W-1:0] f,
			input logic [HZ_W-1:0] lo_lim, input logic [HZ_W-1:0] hi_lim);
		logic [HZ_W-1:0] e;
		e = EDGE_LO[f];
		return (e >= lo_lim) && (e <= hi_lim);
	endfunction
endpackage

@@ rtl/tfe_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfe_in_if
// Spectrum bin channel: valid/ready with bin power and frame end mark.
// ----------------------------------------------------------------------------
interface tfe_in_if;
	logic                            valid;
	logic                            ready;
	logic [tfe_pkg::POWER_W-1:0]     power;
	logic                            frame_end;
	modport source (output valid, output power, output frame_end, input ready);
	modport sink (input valid, input power, input frame_end, output ready);
endinterface

@@ rtl/tfe_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfe_out_if
// Filter result channel: valid/ready with index, energy and flags.
// ----------------------------------------------------------------------------
interface tfe_out_if;
	logic                          valid;
	logic                          ready;
	logic [tfe_pkg::FILT_W-1:0]    filter_index;
	logic [tfe_pkg::ACC_W-1:0]     energy;
	logic                          empty_filter;
	logic                          last_result;
	modport source (output valid, output filter_index, output energy,
		output empty_filter, output last_result, input ready);
	modport sink (input valid, input filter_index, input energy,
		input empty_filter, input last_result, output ready);
endinterface

@@ rtl/tfe_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfe_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tfe_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 12,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/tfe_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfe_div
// Restoring divider for floor(num * 2^16 / den) with num <= den, one bit a cycle.
// ----------------------------------------------------------------------------
module tfe_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tfe_pkg::DIV_W-1:0]     num,
	input  logic [tfe_pkg::DIV_W-1:0]     den,
	output logic                          done,
	output logic [tfe_pkg::Q_W-1:0]       quot
);
	logic                      busy_q;
	logic                      done_q;
	logic [4:0]                cnt_q;
	logic [tfe_pkg::DIV_W-1:0] rem_q;
	logic [tfe_pkg::DIV_W-1:0] den_q;
	logic [tfe_pkg::Q_W-1:0]   quot_q;
	logic [tfe_pkg::DIV_W:0]   rem2;
	logic                      bit_nxt;
	logic                      first_bit;

	assign rem2      = {rem_q, 1'b0};
	assign bit_nxt   = rem2 >= {1'b0, den_q};
	assign first_bit = num >= den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= den;
			rem_q  <= first_bit ? num - den : num;
			quot_q <= {{(tfe_pkg::Q_W-1){1'b0}}, first_bit};
		end else if (busy_q) begin
			rem_q  <= bit_nxt ? tfe_pkg::DIV_W'(rem2 - {1'b0, den_q})
				: tfe_pkg::DIV_W'(rem2);
			quot_q <= {quot_q[tfe_pkg::Q_W-2:0], bit_nxt};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

@@ rtl/triangular_filterbank_energy.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangular_filterbank_energy
// Accumulates weighted spectrum bins into twelve triangular filters.
// ----------------------------------------------------------------------------
// One bin is taken per input transaction and processed to completion before
// the next is accepted. The twelve filters are visited one per cycle, the
// scan pausing on each filter the bin falls strictly inside for the bit-serial
// weight division, the multiply and the accumulator read-modify-write. A bin
// hits at most two filters; a bin past the spectrum end is accepted but adds
// to no filter. A frame end then scans the filters again, emitting one result
// per included filter and stalling while the output side is not ready.
// Accumulators live in a 12 x 48 RAM; a per-entry valid bit marks entries
// written this frame, doubling as the hit flag, and clearing those bits at
// frame end empties the bank without writing the RAM.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module triangular_filterbank_energy (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tfe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tfe_pkg::CFG_DATA_W-1:0]    cfg_data,
	tfe_in_if.sink                            bin_in,
	tfe_out_if.source                         res_out
);
	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_SCAN      = 3'd1;
	localparam logic [2:0] S_DIV       = 3'd2;
	localparam logic [2:0] S_MUL       = 3'd3;
	localparam logic [2:0] S_ACC       = 3'd4;
	localparam logic [2:0] S_EMIT_SCAN = 3'd5;
	localparam logic [2:0] S_EMIT_DATA = 3'd6;

	// Configuration registers.
	logic [tfe_pkg::BW_W-1:0] bw_q;
	logic [tfe_pkg::HZ_W-1:0] low_q;
	logic [tfe_pkg::HZ_W-1:0] high_q;
	logic                     floor_q;

	// Control.
	logic [2:0]                         state_q;
	logic [tfe_pkg::CNT_W-1:0]          cnt_q;
	logic [tfe_pkg::FILT_W-1:0]         f_q;
	logic [tfe_pkg::NUM_FILTERS-1:0]    valid_q;
	logic                               frame_end_q;
	logic                               active_q;

	// Bin payload and datapath.
	logic [tfe_pkg::POWER_W-1:0] power_q;
	logic [tfe_pkg::FREQ_W-1:0]  freq_q;
	logic [tfe_pkg::PROD_W-1:0]  prod_q;

	// Output register.
	logic                        out_valid_q;
	logic [tfe_pkg::FILT_W-1:0]  out_idx_q;
	logic [tfe_pkg::ACC_W-1:0]   out_energy_q;
	logic                        out_empty_q;
	logic                        out_last_q;

	// Filter geometry for the current filter.
	logic [tfe_pkg::CMP_W-1:0]   freq_x, lo_x, hi_x, mid_x;
	logic [tfe_pkg::HZ_W-1:0]    right_hz;
	logic                        incl, in_band, rising, is_last, out_free;
	logic [tfe_pkg::DIV_W-1:0]   num, den;

	// RAM and divider hookup.
	logic                        ram_we, ram_re;
	logic [tfe_pkg::ACC_W-1:0]   ram_wdata, ram_rdata, acc_cur;
	logic [tfe_pkg::ACC_W:0]     acc_sum;
	logic [tfe_pkg::ACC_W-1:0]   energy_nxt;
	logic                        div_start, div_done;
	logic [tfe_pkg::Q_W-1:0]     quot;
	logic [tfe_pkg::W_W-1:0]     weight;

	function automatic logic last_included(input logic [tfe_pkg::FILT_W-1:0] f,
			input logic [tfe_pkg::HZ_W-1:0] lo_lim, input logic [tfe_pkg::HZ_W-1:0] hi_lim);
		logic later;
		later = 1'b0;
		for (int g = 0; g < tfe_pkg::NUM_FILTERS; g++) begin
			if (g > int'(f) && tfe_pkg::included(tfe_pkg::FILT_W'(g), lo_lim, hi_lim)) begin
				later = 1'b1;
			end
		end
		return tfe_pkg::included(f, lo_lim, hi_lim) && !later;
	endfunction

	// Clip the right edge; centre stays at the unclipped midpoint.
	always_comb begin
		right_hz = (tfe_pkg::EDGE_HI[f_q] > high_q) ? high_q : tfe_pkg::EDGE_HI[f_q];
		freq_x   = tfe_pkg::CMP_W'(freq_q);
		lo_x     = tfe_pkg::CMP_W'({tfe_pkg::EDGE_LO[f_q], 16'b0});
		hi_x     = tfe_pkg::CMP_W'({right_hz, 16'b0});
		mid_x    = tfe_pkg::CMP_W'({({1'b0, tfe_pkg::EDGE_LO[f_q]}
			+ {1'b0, tfe_pkg::EDGE_HI[f_q]}), 15'b0});
		incl     = tfe_pkg::included(f_q, low_q, high_q);
		in_band  = incl && (freq_x > lo_x) && (freq_x < hi_x);
		rising   = freq_x <= mid_x;
		num      = rising ? tfe_pkg::DIV_W'(freq_x - lo_x) : tfe_pkg::DIV_W'(hi_x - freq_x);
		den      = rising ? tfe_pkg::DIV_W'(mid_x - lo_x) : tfe_pkg::DIV_W'(hi_x - mid_x);
		is_last  = last_included(f_q, low_q, high_q);
	end

	assign weight   = quot[tfe_pkg::Q_W-1] ? {tfe_pkg::W_W{1'b1}} : quot[tfe_pkg::W_W-1:0];
	assign acc_cur  = valid_q[f_q] ? ram_rdata : '0;
	assign acc_sum  = {1'b0, acc_cur}
		+ tfe_pkg::ACC_W'(prod_q[tfe_pkg::PROD_W-1:tfe_pkg::W_W]);
	assign ram_wdata = acc_sum[tfe_pkg::ACC_W] ? tfe_pkg::ACC_MAX : acc_sum[tfe_pkg::ACC_W-1:0];
	assign ram_we    = (state_q == S_ACC);
	assign ram_re    = ((state_q == S_SCAN) && active_q && in_band)
		|| ((state_q == S_EMIT_SCAN) && incl);
	assign div_start = (state_q == S_SCAN) && active_q && in_band;
	assign out_free  = !out_valid_q || res_out.ready;
	assign energy_nxt = (floor_q && acc_cur < tfe_pkg::FLOOR_VALUE)
		? tfe_pkg::FLOOR_VALUE : acc_cur;

	tfe_ram #(.WIDTH(tfe_pkg::ACC_W), .DEPTH(tfe_pkg::NUM_FILTERS), .AW(tfe_pkg::FILT_W))
	u_acc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (f_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (f_q),
		.rdata (ram_rdata)
	);

	tfe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (den),
		.done   (div_done),
		.quot   (quot)
	);

	// Configuration writes: only while idle, per the block's usage rules; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q    <= tfe_pkg::BIN_WIDTH_RST;
			low_q   <= tfe_pkg::LOW_LIMIT_RST;
			high_q  <= tfe_pkg::HIGH_LIMIT_RST;
			floor_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tfe_pkg::REG_BIN_WIDTH:    bw_q    <= cfg_data;
				tfe_pkg::REG_LOW_LIMIT:    low_q   <= cfg_data[tfe_pkg::HZ_W-1:0];
				tfe_pkg::REG_HIGH_LIMIT:   high_q  <= cfg_data[tfe_pkg::HZ_W-1:0];
				tfe_pkg::REG_FLOOR_ENABLE: floor_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer: scan filters per bin, then emit at frame end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			f_q         <= '0;
			valid_q     <= '0;
			frame_end_q <= 1'b0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a new result or drop the one just taken.
			if (state_q == S_EMIT_DATA && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && res_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (bin_in.valid) begin
						frame_end_q <= bin_in.frame_end;
						active_q    <= cnt_q < tfe_pkg::CNT_W'(tfe_pkg::NUM_SPECTRUM_BINS);
						if (cnt_q < tfe_pkg::CNT_W'(tfe_pkg::NUM_SPECTRUM_BINS)) begin
							cnt_q <= cnt_q + 1'b1;
						end
						f_q     <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (active_q && in_band) begin
						state_q <= S_DIV;
					end else if (!active_q || f_q == tfe_pkg::LAST_FILTER) begin
						f_q     <= '0;
						state_q <= frame_end_q ? S_EMIT_SCAN : S_IDLE;
					end else begin
						f_q <= f_q + 1'b1;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					// Mark the entry written; this is also the filter's hit flag.
					valid_q[f_q] <= 1'b1;
					if (f_q == tfe_pkg::LAST_FILTER) begin
						f_q     <= '0;
						state_q <= frame_end_q ? S_EMIT_SCAN : S_IDLE;
					end else begin
						f_q     <= f_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_EMIT_SCAN: begin
					if (incl) begin
						state_q <= S_EMIT_DATA;
					end else if (f_q == tfe_pkg::LAST_FILTER) begin
						// No filter included: just clear the frame.
						valid_q <= '0;
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						f_q <= f_q + 1'b1;
					end
				end
				S_EMIT_DATA: begin
					if (out_free) begin
						if (is_last) begin
							valid_q <= '0;
							cnt_q   <= '0;
							state_q <= S_IDLE;
						end else begin
							f_q     <= f_q + 1'b1;
							state_q <= S_EMIT_SCAN;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && bin_in.valid) begin
			power_q <= bin_in.power;
			freq_q  <= tfe_pkg::FREQ_W'(bw_q) * tfe_pkg::FREQ_W'(cnt_q);
		end
		if (state_q == S_MUL) begin
			prod_q <= tfe_pkg::PROD_W'(power_q) * tfe_pkg::PROD_W'(weight);
		end
		if (state_q == S_EMIT_DATA && out_free) begin
			out_idx_q    <= f_q;
			out_energy_q <= energy_nxt;
			out_empty_q  <= !valid_q[f_q];
			out_last_q   <= is_last;
		end
	end

	assign bin_in.ready         = (state_q == S_IDLE);
	assign res_out.valid        = out_valid_q;
	assign res_out.filter_index = out_idx_q;
	assign res_out.energy       = out_energy_q;
	assign res_out.empty_filter = out_empty_q;
	assign res_out.last_result  = out_last_q;

	// Bin counter never runs past the spectrum length.
	`ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1,
		cnt_q <= tfe_pkg::CNT_W'(tfe_pkg::NUM_SPECTRUM_BINS))
	// Weight is below one, so a contribution never exceeds the bin power.
	`ASSERT_IMPL(a_contrib_bound, clk, arst_n, state_q == S_ACC,
		prod_q[tfe_pkg::PROD_W-1:tfe_pkg::W_W] <= power_q)
	// Emitting the last result of a frame leaves the bank empty.
	`ASSERT_NEXT(a_frame_clear, clk, arst_n,
		state_q == S_EMIT_DATA && out_free && is_last, valid_q == '0 && cnt_q == '0)
endmodule
